/* src/vpw_pkg.sv */
// shared types, constants and codes for the vpw frame receiver
package vpw_pkg;

   localparam int FRAME_BYTES = 12;
   localparam int CNT_W       = $clog2(FRAME_BYTES + 1);
   localparam int IDX_W       = $clog2(FRAME_BYTES);

   localparam logic [15:0] SHORT_MIN = 16'd34;
   localparam logic [15:0] SHORT_MAX = 16'd96;
   localparam logic [15:0] LONG_MIN  = 16'd97;
   localparam logic [15:0] LONG_MAX  = 16'd163;
   localparam logic [15:0] SOF_MIN   = 16'd163;
   localparam logic [15:0] SOF_MAX   = 16'd239;
   localparam logic [15:0] EOF_MIN   = 16'd239;

   localparam logic [7:0] CRC_POLY = 8'h1D;
   localparam logic [7:0] CRC_INIT = 8'hFF;

   localparam logic KIND_ERROR = 1'b0;
   localparam logic KIND_BYTE  = 1'b1;

   typedef enum logic [1:0] {
      ERR_NONE    = 2'd0,
      ERR_SHORT   = 2'd1,
      ERR_OUTSIDE = 2'd2
   } err_code_type;

   typedef enum logic [2:0] {
      REG_ACTIVE_HIGH = 3'd0,
      REG_CHECK_CRC   = 3'd1,
      REG_IGNORE_0    = 3'd2,
      REG_IGNORE_1    = 3'd3,
      REG_IGNORE_2    = 3'd4,
      REG_IGNORE_3    = 3'd5
   } reg_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECODE,
      ST_CRC,
      ST_CHECK,
      ST_ERROR,
      ST_FETCH,
      ST_SEND
   } state_type;

   typedef struct packed {
      logic       start;
      logic [7:0] seed;
      logic [7:0] data;
   } crc_cmd_type;

   typedef struct packed {
      logic       busy;
      logic       done;
      logic [7:0] crc;
   } crc_sts_type;

endpackage

/* src/vpw_frame_receiver.sv */
// Variable pulse width bus receiver. Each request is one bus edge: the line level after
// the edge and the length of the ended pulse in microseconds. An edge that does not
// complete a byte is accepted and then decoded; an edge that completes a byte also waits
// in the crc state while the bit-serial crc-8 unit folds the byte in one bit per cycle.
// An edge that closes a frame adds a check state, then a fetch and a send state per frame
// byte sent, since every byte is read from the frame memory through a registered port.
// The block takes no new edge until the previous one is fully handled; a finished result
// waits in the output register without blocking decode. Frames with fewer than two bytes,
// a first byte of zero, a first byte marked in the ignore registers, or (with check_crc
// set) a bad trailing crc byte are dropped silently.
module vpw_frame_receiver import vpw_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // [0] new_level, [16:1] pulse_us, rest zero
   // result channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [1:0] error_code, [9:2] data_byte, [13:10] byte_index
   output logic        rsp_tuser,   // kind
   output logic        rsp_tlast,
   // register port
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [5:0]  csr_paddr,
   input  logic [63:0] csr_pwdata,
   output logic [63:0] csr_prdata,
   output logic        csr_pready
);

   // configuration
   logic        active_high_ff;
   logic        check_crc_ff;
   logic [63:0] ignore_ff [4];
   logic        csr_write;
   reg_index_type csr_index;

   // sequencer and frame state
   state_type         state_ff, state_in;
   logic              level_ff;
   logic [15:0]       pulse_ff;
   logic              in_frame_ff;
   logic [2:0]        bit_count_ff;
   logic [CNT_W-1:0]  byte_count_ff;
   logic [7:0]        partial_ff;
   logic [7:0]        id_ff;
   logic [7:0]        last_byte_ff;
   logic [7:0]        crc_running_ff;
   logic [7:0]        crc_before_last_ff;
   err_code_type      err_ff;
   logic [IDX_W-1:0]  rd_idx_ff;
   logic [7:0]        rd_data_ff;
   logic [7:0]        frame_store [FRAME_BYTES];

   // output register
   logic         rsp_valid_ff;
   logic         rsp_kind_ff;
   err_code_type rsp_err_ff;
   logic [7:0]   rsp_data_ff;
   logic [3:0]   rsp_idx_ff;
   logic         rsp_last_ff;

   crc_cmd_type crc_cmd;
   crc_sts_type crc_sts;

   // decode of the registered edge
   logic       was_active, is_short, is_sof, is_eof, bit_val, byte_done;
   logic [7:0] new_byte;
   logic [63:0] ign_word;
   logic       ign_hit, keep, out_free, is_last, accept;
   logic       frame_full;

   // sequencer strobes
   logic start_frame, shift_bit, load_err, load_byte;

   assign accept     = req_tvalid && req_tready;
   assign was_active = ((~level_ff) == active_high_ff);
   assign is_short   = (pulse_ff < SHORT_MIN);
   assign is_sof     = was_active && (pulse_ff >= SOF_MIN) && (pulse_ff <= SOF_MAX);
   assign is_eof     = !was_active && (pulse_ff > EOF_MIN);
   assign bit_val    = was_active ? (pulse_ff <= SHORT_MAX)
                                  : ((pulse_ff >= LONG_MIN) && (pulse_ff <= LONG_MAX));
   assign new_byte   = {partial_ff[6:0], bit_val};
   assign byte_done  = (bit_count_ff == 3'd7);
   assign frame_full = (byte_count_ff == CNT_W'(FRAME_BYTES));

   assign ign_word = ignore_ff[id_ff[7:6]];
   assign ign_hit  = ign_word[id_ff[5:0]];
   assign keep     = (byte_count_ff >= CNT_W'(2)) && (id_ff != 8'h00) && !ign_hit &&
                     (!check_crc_ff || (~crc_before_last_ff == last_byte_ff));

   assign out_free = !rsp_valid_ff || rsp_tready;
   assign is_last  = ((CNT_W'(rd_idx_ff) + CNT_W'(1)) == byte_count_ff);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) state_in = ST_DECODE;
         end
         ST_DECODE: begin
            if (is_short)         state_in = ST_ERROR;
            else if (!in_frame_ff) state_in = is_sof ? ST_IDLE : ST_ERROR;
            else if (is_eof)      state_in = ST_CHECK;
            else if (byte_done)   state_in = ST_CRC;
            else                  state_in = ST_IDLE;
         end
         ST_CRC: begin
            if (crc_sts.done) state_in = frame_full ? ST_CHECK : ST_IDLE;
         end
         ST_CHECK: begin
            state_in = keep ? ST_FETCH : ST_IDLE;
         end
         ST_ERROR: begin
            if (out_free) state_in = ST_IDLE;
         end
         ST_FETCH: begin
            state_in = ST_SEND;
         end
         ST_SEND: begin
            if (out_free) state_in = is_last ? ST_IDLE : ST_FETCH;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // sequencer outputs
   always_comb begin
      req_tready    = 1'b0;
      start_frame   = 1'b0;
      shift_bit     = 1'b0;
      load_err      = 1'b0;
      load_byte     = 1'b0;
      crc_cmd.start = 1'b0;
      crc_cmd.seed  = crc_running_ff;
      crc_cmd.data  = new_byte;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
         end
         ST_DECODE: begin
            if (!is_short && !in_frame_ff && is_sof) start_frame = 1'b1;
            if (!is_short && in_frame_ff && !is_eof) begin
               shift_bit     = 1'b1;
               crc_cmd.start = byte_done;
            end
         end
         ST_ERROR: begin
            load_err = out_free;
         end
         ST_SEND: begin
            load_byte = out_free;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff           <= ST_IDLE;
         in_frame_ff        <= 1'b0;
         bit_count_ff       <= 3'd0;
         byte_count_ff      <= '0;
         partial_ff         <= 8'h00;
         crc_running_ff     <= CRC_INIT;
         crc_before_last_ff <= CRC_INIT;
         rd_idx_ff          <= '0;
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_DECODE && is_short) in_frame_ff <= 1'b0;
         if (state_ff == ST_CHECK) begin
            in_frame_ff <= 1'b0;
            rd_idx_ff   <= '0;
         end
         if (start_frame) begin
            in_frame_ff        <= 1'b1;
            bit_count_ff       <= 3'd0;
            byte_count_ff      <= '0;
            partial_ff         <= 8'h00;
            crc_running_ff     <= CRC_INIT;
            crc_before_last_ff <= CRC_INIT;
         end
         if (shift_bit) begin
            bit_count_ff <= bit_count_ff + 3'd1;
            partial_ff   <= byte_done ? 8'h00 : new_byte;
            if (byte_done) begin
               crc_before_last_ff <= crc_running_ff;
               byte_count_ff      <= byte_count_ff + CNT_W'(1);
            end
         end
         if (state_ff == ST_CRC && crc_sts.done) crc_running_ff <= crc_sts.crc;
         if (load_byte) rd_idx_ff <= rd_idx_ff + IDX_W'(1);
      end
   end

   // edge capture, frame memory and byte side registers
   always_ff @(posedge clock) begin
      if (accept) begin
         level_ff <= req_tdata[0];
         pulse_ff <= req_tdata[16:1];
      end
      if (state_ff == ST_DECODE) err_ff <= is_short ? ERR_SHORT : ERR_OUTSIDE;
      if (shift_bit && byte_done) begin
         frame_store[byte_count_ff[IDX_W-1:0]] <= new_byte;
         last_byte_ff <= new_byte;
         if (byte_count_ff == '0) id_ff <= new_byte;
      end
      rd_data_ff <= frame_store[rd_idx_ff];
   end

   vpw_crc_unit u_crc (
      .clock   (clock),
      .reset   (reset),
      .crc_cmd (crc_cmd),
      .crc_sts (crc_sts)
   );

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load_err || load_byte) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load_err) begin
         rsp_kind_ff <= KIND_ERROR;
         rsp_err_ff  <= err_ff;
         rsp_data_ff <= 8'h00;
         rsp_idx_ff  <= 4'd0;
         rsp_last_ff <= 1'b0;
      end else if (load_byte) begin
         rsp_kind_ff <= KIND_BYTE;
         rsp_err_ff  <= ERR_NONE;
         rsp_data_ff <= rd_data_ff;
         rsp_idx_ff  <= 4'(rd_idx_ff);
         rsp_last_ff <= is_last;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = {2'b00, rsp_idx_ff, rsp_data_ff, rsp_err_ff};

   // register port
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_index  = reg_index_type'(csr_paddr[5:3]);

   always_ff @(posedge clock) begin
      if (reset) begin
         active_high_ff <= 1'b0;
         check_crc_ff   <= 1'b1;
         ignore_ff[0]   <= 64'd0;
         ignore_ff[1]   <= 64'd0;
         ignore_ff[2]   <= 64'd0;
         ignore_ff[3]   <= 64'd0;
      end else if (csr_write) begin
         case (csr_index)
            REG_ACTIVE_HIGH: active_high_ff <= csr_pwdata[0];
            REG_CHECK_CRC:   check_crc_ff   <= csr_pwdata[0];
            REG_IGNORE_0:    ignore_ff[0]   <= csr_pwdata;
            REG_IGNORE_1:    ignore_ff[1]   <= csr_pwdata;
            REG_IGNORE_2:    ignore_ff[2]   <= csr_pwdata;
            REG_IGNORE_3:    ignore_ff[3]   <= csr_pwdata;
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         REG_ACTIVE_HIGH: csr_prdata = {63'd0, active_high_ff};
         REG_CHECK_CRC:   csr_prdata = {63'd0, check_crc_ff};
         REG_IGNORE_0:    csr_prdata = ignore_ff[0];
         REG_IGNORE_1:    csr_prdata = ignore_ff[1];
         REG_IGNORE_2:    csr_prdata = ignore_ff[2];
         REG_IGNORE_3:    csr_prdata = ignore_ff[3];
         default:         csr_prdata = 64'd0;
      endcase
   end

   // the crc unit is never left running once the sequencer is back to idle
   a_crc_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !crc_sts.busy)
      else $error("crc unit busy while idle");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      byte_count_ff <= CNT_W'(FRAME_BYTES))
      else $error("byte count beyond frame size");

   // a frame byte on the output never points past the frame memory
   a_byte_index: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_kind_ff == KIND_BYTE) |-> (rsp_idx_ff < 4'(FRAME_BYTES)))
      else $error("byte index outside frame");

   a_last_kind: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_last_ff) |-> (rsp_kind_ff == KIND_BYTE))
      else $error("last flag on an error report");

endmodule

/* src/vpw_crc_unit.sv */
// bit-serial crc-8 unit, one message bit per cycle
module vpw_crc_unit import vpw_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  crc_cmd_type crc_cmd,
   output crc_sts_type crc_sts
);

   logic [7:0] crc_ff, crc_in;
   logic [7:0] shift_ff, shift_in;
   logic [2:0] step_ff, step_in;
   logic       busy_ff, busy_in;
   logic       done_ff, done_in;
   logic       feedback;

   assign feedback = crc_ff[7] ^ shift_ff[7];

   always_comb begin
      crc_in   = crc_ff;
      shift_in = shift_ff;
      step_in  = step_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      if (crc_cmd.start) begin
         crc_in   = crc_cmd.seed;
         shift_in = crc_cmd.data;
         step_in  = 3'd0;
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         crc_in   = {crc_ff[6:0], 1'b0} ^ (feedback ? CRC_POLY : 8'h00);
         shift_in = {shift_ff[6:0], 1'b0};
         step_in  = step_ff + 3'd1;
         if (step_ff == 3'd7) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= 3'd0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         step_ff <= step_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      crc_ff   <= crc_in;
      shift_ff <= shift_in;
   end

   assign crc_sts.busy = busy_ff;
   assign crc_sts.done = done_ff;
   assign crc_sts.crc  = crc_ff;

endmodule

/* dv/testbench.sv */
// self-checking testbench for the vpw frame receiver: edge stimulus, frame decode prediction
`timescale 1ns / 100ps

module testbench;
   import vpw_pkg::*;

   localparam int CYCLE_LIMIT   = 1_000_000;
   localparam int SETTLE_CYCLES = 64;
   localparam int PHASE_EDGES   = 80;
   localparam int HOLD_CYCLES   = 400;

   typedef struct packed {
      logic         kind;
      err_code_type code;
      logic [7:0]   data;
      logic [3:0]   idx;
      logic         last;
   } rsp_item_type;

   typedef logic [7:0] frame_bytes_type [$];

   typedef enum logic [1:0] {RX_STEADY, RX_CHOPPY, RX_SLUGGISH} rx_mode_type;

   logic        clock;
   logic        reset       = 1'b1;
   logic        req_tvalid  = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata   = '0;
   logic        rsp_tvalid;
   logic        rsp_tready  = 1'b0;
   logic [15:0] rsp_tdata;
   logic        rsp_tuser;
   logic        rsp_tlast;
   logic        csr_psel    = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite  = 1'b0;
   logic [5:0]  csr_paddr   = '0;
   logic [63:0] csr_pwdata  = '0;
   logic [63:0] csr_prdata;
   logic        csr_pready;

   // receiver-side mirror of the block
   logic        cfg_active_high = 1'b0;
   logic        cfg_check_crc   = 1'b1;
   logic [63:0] cfg_ignore [4] = '{default: '0};
   logic        rx_in_frame     = 1'b0;
   int          rx_bits         = 0;
   int          rx_bytes        = 0;
   logic [7:0]  rx_shift        = '0;
   logic [7:0]  rx_store [FRAME_BYTES];
   logic [7:0]  rx_crc          = CRC_INIT;
   logic [7:0]  rx_crc_prev     = CRC_INIT;

   rsp_item_type awaited [$];
   int          mismatches      = 0;
   int          edges_accepted  = 0;
   int          burst_left      = 0;
   int          cycle_count     = 0;
   int          hold_request    = 0;
   int          hold_left       = 0;
   int          stall_left      = 0;
   rx_mode_type stall_mode      = RX_STEADY;

   vpw_frame_receiver DUT (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("mismatch at %0t: %s got %0h expected %0h", $time, what, got, want);
      mismatches++;
   endtask

   function automatic logic [7:0] crc8_fold(input logic [7:0] crc, input logic [7:0] b);
      logic [7:0] c;
      logic       fb;
      c = crc;
      for (int i = 7; i >= 0; i--) begin
         fb = c[7] ^ b[i];
         c = {c[6:0], 1'b0};
         if (fb) c = c ^ CRC_POLY;
      end
      return c;
   endfunction

   function automatic rsp_item_type make_rsp(input logic kind, input err_code_type code,
                                             input logic [7:0] data, input logic [3:0] idx,
                                             input logic last);
      rsp_item_type r;
      r.kind = kind;
      r.code = code;
      r.data = data;
      r.idx  = idx;
      r.last = last;
      return r;
   endfunction

   task automatic close_frame();
      int         n;
      logic [7:0] id;
      n = rx_bytes;
      rx_in_frame = 1'b0;
      if (n < 2) return;
      id = rx_store[0];
      if (id == 8'd0) return;
      if (cfg_ignore[id[7:6]][id[5:0]]) return;
      if (cfg_check_crc && ~rx_crc_prev != rx_store[n - 1]) return;
      for (int i = 0; i < n; i++)
         awaited.push_back(make_rsp(KIND_BYTE, ERR_NONE, rx_store[i], 4'(i), i == n - 1));
   endtask

   // expected results of one accepted edge
   task automatic decode_edge(input logic lvl, input logic [15:0] us);
      logic was_active;
      logic bitv;
      was_active = ((~lvl) == cfg_active_high);
      if (us < SHORT_MIN) begin
         rx_in_frame = 1'b0;
         awaited.push_back(make_rsp(KIND_ERROR, ERR_SHORT, 8'd0, 4'd0, 1'b0));
      end else if (!rx_in_frame) begin
         if (was_active && us >= SOF_MIN && us <= SOF_MAX) begin
            rx_in_frame = 1'b1;
            rx_bits     = 0;
            rx_bytes    = 0;
            rx_shift    = '0;
            rx_crc      = CRC_INIT;
            rx_crc_prev = CRC_INIT;
         end else begin
            awaited.push_back(make_rsp(KIND_ERROR, ERR_OUTSIDE, 8'd0, 4'd0, 1'b0));
         end
      end else if (!was_active && us > EOF_MIN) begin
         close_frame();
      end else begin
         if (!was_active) bitv = (us >= LONG_MIN && us <= LONG_MAX);
         else bitv = (us <= SHORT_MAX);
         rx_shift = {rx_shift[6:0], bitv};
         rx_bits++;
         if (rx_bits == 8) begin
            rx_store[rx_bytes] = rx_shift;
            rx_crc_prev = rx_crc;
            rx_crc = crc8_fold(rx_crc, rx_shift);
            rx_bytes++;
            rx_bits  = 0;
            rx_shift = '0;
         end
         if (rx_bytes >= FRAME_BYTES) close_frame();
      end
   endtask

   always @(posedge clock) begin : check_results
      rsp_item_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (awaited.size() == 0) begin
            report_mismatch("unexpected result", 64'({rsp_tuser, rsp_tlast, rsp_tdata}), '0);
         end else begin
            want = awaited.pop_front();
            if (rsp_tuser !== want.kind)
               report_mismatch("kind", 64'(rsp_tuser), 64'(want.kind));
            if (rsp_tdata[1:0] !== want.code)
               report_mismatch("error_code", 64'(rsp_tdata[1:0]), 64'(want.code));
            if (rsp_tdata[9:2] !== want.data)
               report_mismatch("data_byte", 64'(rsp_tdata[9:2]), 64'(want.data));
            if (rsp_tdata[13:10] !== want.idx)
               report_mismatch("byte_index", 64'(rsp_tdata[13:10]), 64'(want.idx));
            if (rsp_tlast !== want.last)
               report_mismatch("last", 64'(rsp_tlast), 64'(want.last));
         end
      end
   end

   // receiver stalls; a requested hold-off overrides the pattern
   always @(posedge clock) begin
      if (hold_request > 0) begin
         hold_left    = hold_request;
         hold_request = 0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         if (stall_left == 0) begin
            stall_mode = rx_mode_type'($urandom_range(0, 2));
            stall_left = $urandom_range(10, 150);
         end
         stall_left--;
         case (stall_mode)
            RX_STEADY: rsp_tready <= 1'b1;
            RX_CHOPPY: rsp_tready <= 1'($urandom_range(0, 1));
            default:   rsp_tready <= ($urandom_range(0, 4) == 0);
         endcase
      end
   end

   task automatic send_edge(input logic lvl, input logic [15:0] us);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 3);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 40);
      end
      burst_left--;
      req_tdata  <= {7'd0, us, lvl};
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      edges_accepted++;
      decode_edge(lvl, us);
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (awaited.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input reg_index_type r, input logic [63:0] v);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {r, 3'b000};
      csr_pwdata  <= v;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      case (r)
         REG_ACTIVE_HIGH: cfg_active_high = v[0];
         REG_CHECK_CRC:   cfg_check_crc = v[0];
         REG_IGNORE_0:    cfg_ignore[0] = v;
         REG_IGNORE_1:    cfg_ignore[1] = v;
         REG_IGNORE_2:    cfg_ignore[2] = v;
         default:         cfg_ignore[3] = v;
      endcase
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic csr_check(input reg_index_type r);
      logic [63:0] got;
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= {r, 3'b000};
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      got = csr_prdata;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      case (r)
         REG_ACTIVE_HIGH:
            if (got[0] !== cfg_active_high)
               report_mismatch("active_high", 64'(got[0]), 64'(cfg_active_high));
         REG_CHECK_CRC:
            if (got[0] !== cfg_check_crc)
               report_mismatch("check_crc", 64'(got[0]), 64'(cfg_check_crc));
         default:
            if (got !== cfg_ignore[r - REG_IGNORE_0])
               report_mismatch("ignore_ids", got, cfg_ignore[r - REG_IGNORE_0]);
      endcase
   endtask

   // pulse width for one bit; low picks walk the decode boundaries
   function automatic logic [15:0] bit_width(input logic passive, input logic value,
                                             input int unsigned pick);
      logic [15:0] w;
      if (passive && value) begin
         case (pick % 3)
            0:       w = LONG_MIN;
            1:       w = LONG_MAX;
            default: w = 16'($urandom_range(LONG_MIN, LONG_MAX));
         endcase
      end else if (passive) begin
         case (pick % 5)
            0:       w = SHORT_MIN;
            1:       w = SHORT_MAX;
            2:       w = LONG_MAX + 16'd1;
            3:       w = SOF_MAX;
            default: w = 16'($urandom_range(0, 1) ? $urandom_range(SHORT_MIN, SHORT_MAX)
                                                  : $urandom_range(LONG_MAX + 1, SOF_MAX));
         endcase
      end else if (value) begin
         case (pick % 3)
            0:       w = SHORT_MIN;
            1:       w = SHORT_MAX;
            default: w = 16'($urandom_range(SHORT_MIN, SHORT_MAX));
         endcase
      end else begin
         case (pick % 5)
            0:       w = SHORT_MAX + 16'd1;
            1:       w = SOF_MAX;
            2:       w = EOF_MIN + 16'd1;
            3:       w = 16'hFFFF;
            default: w = 16'($urandom_range(SHORT_MAX + 1, 2000));
         endcase
      end
      return w;
   endfunction

   // start of frame, body bits msb first on alternating levels, optional short
   // pulse at bit cut_at, then the end-of-frame gap
   task automatic send_frame(input frame_bytes_type body, input int tail_bits,
                             input int cut_at, input bit sweep);
      int         nbits;
      logic       passive;
      logic       bitv;
      logic       act_lvl;
      logic       pas_lvl;
      logic [15:0] eof_us;
      act_lvl = ~cfg_active_high;
      pas_lvl = cfg_active_high;
      send_edge(act_lvl, sweep ? SOF_MIN : 16'($urandom_range(SOF_MIN, SOF_MAX)));
      nbits = body.size() * 8 + tail_bits;
      for (int k = 0; k < nbits; k++) begin
         passive = (k % 2 == 0);
         bitv = (k < body.size() * 8) ? body[k / 8][7 - k % 8] : 1'($urandom_range(0, 1));
         if (k == cut_at)
            send_edge(passive ? pas_lvl : act_lvl, 16'($urandom_range(0, SHORT_MIN - 1)));
         else
            send_edge(passive ? pas_lvl : act_lvl,
                      bit_width(passive, bitv, sweep ? k : $urandom));
      end
      case ($urandom_range(0, 4))
         0, 1:    eof_us = 16'($urandom_range(EOF_MIN + 1, 400));
         2, 3:    eof_us = 16'($urandom_range(EOF_MIN + 1, 16'hFFFF));
         default: eof_us = 16'hFFFF;
      endcase
      send_edge(pas_lvl, sweep ? EOF_MIN + 16'd1 : eof_us);
   endtask

   task automatic random_frame();
      frame_bytes_type body;
      logic [7:0]      hot_ids [5] = '{8'h01, 8'h40, 8'h80, 8'h6C, 8'hFF};
      logic [7:0]      crc;
      int              n;
      int              pct;
      int              tail;
      int              cut;
      pct = $urandom_range(0, 99);
      if (pct < 5)       n = $urandom_range(0, 1);
      else if (pct < 75) n = $urandom_range(2, 4);
      else if (pct < 92) n = $urandom_range(5, FRAME_BYTES - 1);
      else               n = FRAME_BYTES;
      for (int i = 0; i < n; i++) body.push_back(8'($urandom));
      if (n > 0) begin
         pct = $urandom_range(0, 99);
         if (pct < 8)       body[0] = 8'd0;
         else if (pct < 40) body[0] = hot_ids[$urandom_range(0, 4)];
      end
      if (n >= 2 && $urandom_range(0, 9) < 8) begin
         crc = CRC_INIT;
         for (int i = 0; i < n - 1; i++) crc = crc8_fold(crc, body[i]);
         body[n - 1] = ~crc;
      end
      tail = ($urandom_range(0, 9) == 0) ? 2 * $urandom_range(1, 3) : 0;
      cut  = ($urandom_range(0, 19) == 0) ? $urandom_range(0, n * 8 + tail) : -1;
      // close whatever a previous noise edge may have opened
      if (rx_in_frame) send_edge(cfg_active_high, 16'd300);
      send_frame(body, tail, cut, 1'b0);
   endtask

   task automatic noise_edge();
      logic [15:0] us;
      case ($urandom_range(0, 9))
         0, 1, 2: us = 16'($urandom_range(0, SHORT_MIN - 1));
         3, 4, 5, 6: us = 16'($urandom_range(SHORT_MIN, 300));
         7:       us = 16'hFFFF;
         default: us = 16'($urandom);
      endcase
      send_edge(1'($urandom_range(0, 1)), us);
   endtask

   task automatic test_registers();
      csr_check(REG_ACTIVE_HIGH);
      csr_check(REG_CHECK_CRC);
      csr_check(REG_IGNORE_0);
      csr_check(REG_IGNORE_3);
      csr_write(REG_ACTIVE_HIGH, 64'd1);
      csr_write(REG_CHECK_CRC, 64'd0);
      csr_write(REG_IGNORE_0, '1);
      csr_write(REG_IGNORE_1, 64'hA5A5_5A5A_0F0F_F0F0);
      csr_write(REG_IGNORE_2, '1);
      csr_write(REG_IGNORE_3, 64'h8000_0000_0000_0001);
      for (int r = REG_ACTIVE_HIGH; r <= REG_IGNORE_3; r++) csr_check(reg_index_type'(r));
      csr_write(REG_ACTIVE_HIGH, 64'd0);
      csr_write(REG_CHECK_CRC, 64'd1);
      csr_write(REG_IGNORE_0, '0);
      csr_write(REG_IGNORE_1, '0);
      csr_write(REG_IGNORE_2, '0);
      csr_write(REG_IGNORE_3, '0);
      for (int r = REG_ACTIVE_HIGH; r <= REG_IGNORE_3; r++) csr_check(reg_index_type'(r));
   endtask

   task automatic test_edge_errors();
      logic act_lvl;
      logic pas_lvl;
      act_lvl = ~cfg_active_high;
      pas_lvl = cfg_active_high;
      send_edge(pas_lvl, 16'd0);
      send_edge(act_lvl, SHORT_MIN - 16'd1);
      send_edge(pas_lvl, 16'd200);
      send_edge(act_lvl, SOF_MIN - 16'd1);
      send_edge(act_lvl, SOF_MAX + 16'd1);
      send_edge(act_lvl, 16'hFFFF);
      // a short pulse aborts a frame that has just started
      send_edge(act_lvl, SOF_MIN);
      send_edge(pas_lvl, SHORT_MIN - 16'd1);
      send_edge(pas_lvl, 16'd300);
      // empty frame is dropped silently
      send_edge(act_lvl, SOF_MAX);
      send_edge(pas_lvl, 16'hFFFF);
      wait_drained();
   endtask

   task automatic test_boundary_frame();
      frame_bytes_type body;
      body.push_back(8'hA5);
      body.push_back(~crc8_fold(CRC_INIT, 8'hA5));
      send_frame(body, 0, -1, 1'b1);
      wait_drained();
   endtask

   task automatic test_backpressure();
      frame_bytes_type body;
      logic [7:0]      crc;
      hold_request = HOLD_CYCLES;
      @(posedge clock);
      for (int i = 0; i < 5; i++) send_edge(1'($urandom_range(0, 1)), 16'd10);
      crc = CRC_INIT;
      for (int i = 0; i < 3; i++) begin
         body.push_back(8'($urandom_range(1, 255)));
         crc = crc8_fold(crc, body[i]);
      end
      body.push_back(~crc);
      send_frame(body, 0, -1, 1'b0);
      wait_drained();
   endtask

   task automatic test_random_frames();
      int target;
      for (int phase = 0; phase < 5; phase++) begin
         wait_drained();
         case (phase)
            0: begin
               csr_write(REG_ACTIVE_HIGH, 64'd0);
               csr_write(REG_CHECK_CRC, 64'd1);
            end
            1: begin
               csr_write(REG_ACTIVE_HIGH, 64'd1);
               csr_write(REG_CHECK_CRC, 64'd0);
               csr_write(REG_IGNORE_0, 64'h2);
               csr_write(REG_IGNORE_1, 64'h1);
               csr_write(REG_IGNORE_3, 64'h8000_0000_0000_0000);
            end
            2: begin
               csr_write(REG_CHECK_CRC, 64'd1);
               csr_write(REG_IGNORE_2, '1);
            end
            3: begin
               // everything ignored: only error reports come back
               csr_write(REG_ACTIVE_HIGH, 64'd0);
               csr_write(REG_IGNORE_0, '1);
               csr_write(REG_IGNORE_1, '1);
               csr_write(REG_IGNORE_2, '1);
               csr_write(REG_IGNORE_3, '1);
            end
            default: begin
               csr_write(REG_ACTIVE_HIGH, 64'($urandom_range(0, 1)));
               csr_write(REG_CHECK_CRC, 64'd0);
               csr_write(REG_IGNORE_0, {$urandom, $urandom});
               csr_write(REG_IGNORE_1, {$urandom, $urandom});
               csr_write(REG_IGNORE_2, {$urandom, $urandom});
               csr_write(REG_IGNORE_3, {$urandom, $urandom});
            end
         endcase
         target = edges_accepted + PHASE_EDGES;
         while (edges_accepted < target) begin
            if ($urandom_range(0, 99) < 75) random_frame();
            else repeat ($urandom_range(1, 4)) noise_edge();
            if ($urandom_range(0, 24) == 0) wait_drained();
         end
      end
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_registers();
      test_edge_errors();
      test_boundary_frame();
      test_backpressure();
      test_random_frames();
      wait_drained();
      if (mismatches == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
